FILE: src/cup_pkg.sv
// Shared types and constants for the 4:2:0 to 4:4:4 chroma upsampler.
package cup_pkg;

   localparam int unsigned MAX_CHROMA_WIDTH  = 1024;
   localparam int unsigned MAX_CHROMA_HEIGHT = 1024;

   localparam int unsigned SAMPLE_W    = 8;
   localparam int unsigned DIM_W       = 11;
   localparam int unsigned BLOCK_POS_W = 10;
   localparam int unsigned COL_W       = $clog2(MAX_CHROMA_WIDTH);
   localparam int unsigned ROW_W       = $clog2(MAX_CHROMA_HEIGHT);

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_HEIGHT = CSR_INDEX_W'(1);

   localparam int unsigned RESET_CHROMA_WIDTH  = 360;
   localparam int unsigned RESET_CHROMA_HEIGHT = 288;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Number of blocks one sample can complete, one mask bit each, raster order.
   localparam int unsigned NUM_BLOCKS = 4;

   // 3x3 window: [row][col], row 0 = two rows up, col 0 = two columns left.
   typedef logic [2:0][2:0][SAMPLE_W-1:0] win_type;

   typedef struct packed {
      win_type               win;
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      col;
      logic                  row_is0;
      logic                  row_is1;
      logic                  col_is0;
      logic                  col_is1;
      logic [NUM_BLOCKS-1:0] mask;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } q_status_type;

endpackage

FILE: src/cup_if.sv
// Channel interfaces of the chroma upsampler: config writes, samples, results.
interface cup_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cup_pkg::CSR_INDEX_W-1:0]  index;
   logic [cup_pkg::DIM_W-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

interface cup_req_if;
   logic                          valid;
   logic                          ready;
   logic [cup_pkg::SAMPLE_W-1:0]  sample;
   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface

interface cup_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cup_pkg::BLOCK_POS_W-1:0]  block_col;
   logic [cup_pkg::BLOCK_POS_W-1:0]  block_row;
   logic [cup_pkg::SAMPLE_W-1:0]     top_left;
   logic [cup_pkg::SAMPLE_W-1:0]     top_right;
   logic [cup_pkg::SAMPLE_W-1:0]     bottom_left;
   logic [cup_pkg::SAMPLE_W-1:0]     bottom_right;
   logic                             run_end;
   modport source (output valid, block_col, block_row, top_left, top_right,
                   bottom_left, bottom_right, run_end, input ready);
   modport sink (input valid, block_col, block_row, top_left, top_right,
                 bottom_left, bottom_right, run_end, output ready);
endinterface

FILE: src/cup_front.sv
// Front end: frame position, line buffer, 3x3 window and block classification.
module cup_front (
   input  logic                  clock,
   input  logic                  reset,
   cup_csr_if.sink               csr_ch,
   cup_req_if.sink               req_ch,
   input  cup_pkg::q_status_type q_status,
   output cup_pkg::push_type     q_push
);

   localparam int unsigned WORD_W = 2 * cup_pkg::SAMPLE_W;

   logic [cup_pkg::COL_W-1:0] col_ff, col_in;
   logic [cup_pkg::ROW_W-1:0] row_ff, row_in;
   logic [cup_pkg::COL_W-1:0] last_col_ff, last_col_in;
   logic [cup_pkg::ROW_W-1:0] last_row_ff, last_row_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic [cup_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic [cup_pkg::COL_W-1:0]    s1_col_ff;
   logic [cup_pkg::ROW_W-1:0]    s1_row_ff;
   logic                         s1_last_col_ff;
   logic                         s1_last_row_ff;
   logic                         s1_byp_ff;

   // Each word holds column j of the two rows above the current one: {older, newer}.
   logic [WORD_W-1:0] line_mem_ff [cup_pkg::MAX_CHROMA_WIDTH];
   logic [WORD_W-1:0] mem_rd_ff;
   logic [WORD_W-1:0] last_wr_ff;

   cup_pkg::win_type win_ff;

   logic                         accept;
   logic                         csr_write;
   logic [cup_pkg::QCNT_W:0]     in_flight;
   logic [WORD_W-1:0]            old_word;
   logic [WORD_W-1:0]            wr_word;
   logic [2:0][cup_pkg::SAMPLE_W-1:0] new_col;
   int unsigned                  dim;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   assign in_flight = (cup_pkg::QCNT_W+1)'(q_status.count)
                    + (cup_pkg::QCNT_W+1)'(s1_valid_ff);
   assign req_ch.ready = in_flight < (cup_pkg::QCNT_W+1)'(cup_pkg::QUEUE_DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;

   // Clamp register values to 1..MAX and keep the last index.
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      dim         = 0;
      if (csr_write) begin
         dim = int'(csr_ch.data);
         unique case (csr_ch.index)
            cup_pkg::REG_CHROMA_WIDTH: begin
               if (dim == 0) dim = 1;
               if (dim > cup_pkg::MAX_CHROMA_WIDTH) dim = cup_pkg::MAX_CHROMA_WIDTH;
               last_col_in = cup_pkg::COL_W'(dim - 1);
            end
            cup_pkg::REG_CHROMA_HEIGHT: begin
               if (dim == 0) dim = 1;
               if (dim > cup_pkg::MAX_CHROMA_HEIGHT) dim = cup_pkg::MAX_CHROMA_HEIGHT;
               last_row_in = cup_pkg::ROW_W'(dim - 1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write && (csr_ch.index == cup_pkg::REG_CHROMA_WIDTH ||
                        csr_ch.index == cup_pkg::REG_CHROMA_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in = accept;

   // Forward the word written last cycle when the same column is read again.
   assign old_word   = s1_byp_ff ? last_wr_ff : mem_rd_ff;
   assign wr_word    = {old_word[cup_pkg::SAMPLE_W-1:0], s1_sample_ff};
   assign new_col[0] = old_word[WORD_W-1:cup_pkg::SAMPLE_W];
   assign new_col[1] = old_word[cup_pkg::SAMPLE_W-1:0];
   assign new_col[2] = s1_sample_ff;

   always_comb begin
      q_push.valid       = 1'b0;
      q_push.rec.row     = s1_row_ff;
      q_push.rec.col     = s1_col_ff;
      q_push.rec.row_is0 = (s1_row_ff == '0);
      q_push.rec.row_is1 = (s1_row_ff == cup_pkg::ROW_W'(1));
      q_push.rec.col_is0 = (s1_col_ff == '0);
      q_push.rec.col_is1 = (s1_col_ff == cup_pkg::COL_W'(1));
      q_push.rec.mask[0] = (s1_row_ff != '0) && (s1_col_ff != '0);
      q_push.rec.mask[1] = (s1_row_ff != '0) && s1_last_col_ff;
      q_push.rec.mask[2] = s1_last_row_ff && (s1_col_ff != '0);
      q_push.rec.mask[3] = s1_last_row_ff && s1_last_col_ff;
      for (int r = 0; r < 3; r++) begin
         q_push.rec.win[r][0] = win_ff[r][1];
         q_push.rec.win[r][1] = win_ff[r][2];
         q_push.rec.win[r][2] = new_col[r];
      end
      q_push.valid = s1_valid_ff && (q_push.rec.mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= cup_pkg::COL_W'(cup_pkg::RESET_CHROMA_WIDTH - 1);
         last_row_ff <= cup_pkg::ROW_W'(cup_pkg::RESET_CHROMA_HEIGHT - 1);
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff      <= line_mem_ff[col_ff];
         s1_sample_ff   <= req_ch.sample;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= (col_ff == last_col_ff);
         s1_last_row_ff <= (row_ff == last_row_ff);
         s1_byp_ff      <= s1_valid_ff && (s1_col_ff == col_ff);
      end
      if (s1_valid_ff) begin
         line_mem_ff[s1_col_ff] <= wr_word;
         last_wr_ff             <= wr_word;
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
            win_ff[r][2] <= new_col[r];
         end
      end
   end

endmodule

FILE: src/cup_queue.sv
// Short queue of classified windows between the front and the back end.
module cup_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cup_pkg::push_type     q_push,
   input  logic                  q_pop,
   output cup_pkg::rec_type      q_head,
   output cup_pkg::q_status_type q_status
);

   cup_pkg::rec_type slots_ff [cup_pkg::QUEUE_DEPTH];

   logic [cup_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cup_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cup_pkg::QCNT_W-1:0] count_ff, count_in;

   assign q_head          = slots_ff[rd_ptr_ff];
   assign q_status.count  = count_ff;
   assign q_status.empty  = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == cup_pkg::QPTR_W'(cup_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == cup_pkg::QPTR_W'(cup_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({q_push.valid, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) slots_ff[wr_ptr_ff] <= q_push.rec;
   end

endmodule

FILE: src/cup_back.sv
// Back end: expand each window into its blocks, filter, and register the result.
module cup_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cup_pkg::rec_type      q_head,
   input  cup_pkg::q_status_type q_status,
   output logic                  q_pop,
   cup_rsp_if.source             rsp_ch
);

   localparam int unsigned ACC_W = cup_pkg::SAMPLE_W + 4;

   function automatic logic [cup_pkg::SAMPLE_W-1:0] mix(
      input logic [cup_pkg::SAMPLE_W-1:0] corner,
      input logic [cup_pkg::SAMPLE_W-1:0] vert,
      input logic [cup_pkg::SAMPLE_W-1:0] horz,
      input logic [cup_pkg::SAMPLE_W-1:0] centre
   );
      logic [ACC_W-1:0] side;
      logic [ACC_W-1:0] acc;
      side = ACC_W'(vert) + ACC_W'(horz);
      acc  = ACC_W'(corner) + (side << 1) + side + (ACC_W'(centre) << 3)
           + ACC_W'(centre) + ACC_W'(8);
      return acc[ACC_W-1:4];
   endfunction

   logic             work_valid_ff, work_valid_in;
   cup_pkg::rec_type work_ff, work_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cup_pkg::BLOCK_POS_W-1:0] rsp_col_ff, rsp_row_ff;
   logic [cup_pkg::SAMPLE_W-1:0]    rsp_tl_ff, rsp_tr_ff, rsp_bl_ff, rsp_br_ff;
   logic                            rsp_end_ff;

   logic                            out_adv;
   logic                            fire;
   logic                            done;
   logic [1:0]                      sel;
   logic                            col_hi;
   logic                            row_hi;
   logic [cup_pkg::NUM_BLOCKS-1:0]  remaining;
   logic                            clamp_up, clamp_down, clamp_left, clamp_right;
   logic [cup_pkg::SAMPLE_W-1:0]    centre;
   logic [2:0][2:0][cup_pkg::SAMPLE_W-1:0] nb;
   logic [1:0]                      ri, ci;
   logic [cup_pkg::ROW_W-1:0]       blk_row;
   logic [cup_pkg::COL_W-1:0]       blk_col;

   // Lowest pending block first: bit 0 steps the column, bit 1 the row.
   always_comb begin
      if (work_ff.mask[0])      sel = 2'd0;
      else if (work_ff.mask[1]) sel = 2'd1;
      else if (work_ff.mask[2]) sel = 2'd2;
      else                      sel = 2'd3;
   end

   assign col_hi    = sel[0];
   assign row_hi    = sel[1];
   assign remaining = work_ff.mask & ~(cup_pkg::NUM_BLOCKS'(1) << sel);

   assign clamp_up    = row_hi ? work_ff.row_is0 : work_ff.row_is1;
   assign clamp_down  = row_hi;
   assign clamp_left  = col_hi ? work_ff.col_is0 : work_ff.col_is1;
   assign clamp_right = col_hi;

   assign centre  = work_ff.win[{1'b0, row_hi} + 2'd1][{1'b0, col_hi} + 2'd1];
   assign blk_row = row_hi ? work_ff.row : work_ff.row - 1'b1;
   assign blk_col = col_hi ? work_ff.col : work_ff.col - 1'b1;

   // Replace every neighbor outside the plane by the centre sample.
   always_comb begin
      ri = '0;
      ci = '0;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            ri = 2'(dr) + {1'b0, row_hi};
            ci = 2'(dc) + {1'b0, col_hi};
            if (ri == 2'd3) ri = 2'd2;
            if (ci == 2'd3) ci = 2'd2;
            if ((dr == 0 && clamp_up) || (dr == 2 && clamp_down) ||
                (dc == 0 && clamp_left) || (dc == 2 && clamp_right)) begin
               nb[dr][dc] = centre;
            end else begin
               nb[dr][dc] = work_ff.win[ri][ci];
            end
         end
      end
   end

   assign out_adv = !rsp_valid_ff || rsp_ch.ready;
   assign fire    = work_valid_ff && out_adv;
   assign done    = fire && (remaining == '0);
   assign q_pop   = (!work_valid_ff || done) && !q_status.empty;

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (q_pop) begin
         work_in       = q_head;
         work_valid_in = 1'b1;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (fire) begin
         work_in.mask = remaining;
      end
      if (fire)              rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (fire) begin
         rsp_col_ff <= cup_pkg::BLOCK_POS_W'(blk_col);
         rsp_row_ff <= cup_pkg::BLOCK_POS_W'(blk_row);
         rsp_tl_ff  <= mix(nb[0][0], nb[0][1], nb[1][0], centre);
         rsp_tr_ff  <= mix(nb[0][2], nb[0][1], nb[1][2], centre);
         rsp_bl_ff  <= mix(nb[2][0], nb[2][1], nb[1][0], centre);
         rsp_br_ff  <= mix(nb[2][2], nb[2][1], nb[1][2], centre);
         rsp_end_ff <= (remaining == '0);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.block_col    = rsp_col_ff;
   assign rsp_ch.block_row    = rsp_row_ff;
   assign rsp_ch.top_left     = rsp_tl_ff;
   assign rsp_ch.top_right    = rsp_tr_ff;
   assign rsp_ch.bottom_left  = rsp_bl_ff;
   assign rsp_ch.bottom_right = rsp_br_ff;
   assign rsp_ch.run_end      = rsp_end_ff;

endmodule

FILE: src/chroma_420_to_444_upsampler.sv
// Top level of the 4:2:0 to 4:4:4 bilinear chroma upsampler.
// Feed the chroma plane in raster order, one sample per transaction; each 2x2
// block of upsampled output leaves as one result transaction once its last
// neighbor has arrived, with run_end set on the final result a sample causes.
// The front end takes one sample per cycle while the window queue has room: it
// reads and rewrites one word of a 1024 x 16-bit line buffer per sample (single
// read and write port, forwarded when a one-column plane hits the same word
// back to back). The back end delivers one result per cycle while the receiver
// is ready, so interior samples, one block each, sustain one per cycle; the
// last sample of every row but the first and every later sample of the last
// row complete two blocks, the final sample of the frame four. A sample passes
// the s1 registers, window queue, work register and result register. Writing
// either dimension register restarts the frame at row 0, column 0.
module chroma_420_to_444_upsampler (
   input  logic      clock,
   input  logic      reset,
   cup_csr_if.sink   csr_ch,
   cup_req_if.sink   req_ch,
   cup_rsp_if.source rsp_ch
);

   cup_pkg::push_type     q_push;
   cup_pkg::rec_type      q_head;
   cup_pkg::q_status_type q_status;
   logic                  q_pop;

   cup_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push)
   );

   cup_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   cup_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> (q_status.count < cup_pkg::QCNT_W'(cup_pkg::QUEUE_DEPTH)))
      else $error("window queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("window queue popped while empty");

   a_push_follows_accept: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> $past(req_ch.valid && req_ch.ready))
      else $error("window pushed without an accepted sample");

endmodule

FILE: dv/chroma_420_to_444_upsampler_test.sv
// Self-checking testbench for the 4:2:0 to 4:4:4 chroma upsampler.
module chroma_420_to_444_upsampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned PHASE_ITEMS   = 18;

   // Indexes outside the register map: writes there must be ignored.
   localparam logic [cup_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_2 = cup_pkg::CSR_INDEX_W'(2);
   localparam logic [cup_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_3 = cup_pkg::CSR_INDEX_W'(3);

   typedef struct packed {
      logic [cup_pkg::BLOCK_POS_W-1:0] block_col;
      logic [cup_pkg::BLOCK_POS_W-1:0] block_row;
      logic [cup_pkg::SAMPLE_W-1:0]    top_left;
      logic [cup_pkg::SAMPLE_W-1:0]    top_right;
      logic [cup_pkg::SAMPLE_W-1:0]    bottom_left;
      logic [cup_pkg::SAMPLE_W-1:0]    bottom_right;
      logic                            run_end;
   } upsampled_block_type;

   logic clock = 1'b0;
   logic reset;

   cup_csr_if csr_ch();
   cup_req_if req_ch();
   cup_rsp_if rsp_ch();

   chroma_420_to_444_upsampler i_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   logic [cup_pkg::SAMPLE_W-1:0] pending_samples[$];
   upsampled_block_type          expected_blocks[$];
   int unsigned                  sender_idle_pct;
   int unsigned                  receiver_stall_pct;
   int unsigned                  quiet_cycles;
   logic                         sample_taken;
   logic                         mismatch_seen;

   // Local copy of the upsampler state.
   logic [cup_pkg::SAMPLE_W-1:0] chroma_store [3*cup_pkg::MAX_CHROMA_WIDTH];
   int unsigned                  next_col;
   int unsigned                  next_row;
   logic [cup_pkg::DIM_W-1:0]    width_setting;
   logic [cup_pkg::DIM_W-1:0]    height_setting;

   function automatic int unsigned used_dim(logic [cup_pkg::DIM_W-1:0] value,
                                            int unsigned limit);
      if (value == '0)
         return 1;
      return (value > limit) ? limit : 32'(value);
   endfunction

   function automatic int stored(int r, int c);
      return int'(chroma_store[(r % 3) * cup_pkg::MAX_CHROMA_WIDTH + c]);
   endfunction

   // Fall back to the centre when the neighbor lies outside the plane.
   function automatic int neighbor(int r, int c, int dr, int dc, int w, int h, int centre);
      if ((dr < 0 && r == 0) || (dr > 0 && r + 1 >= h) ||
          (dc < 0 && c == 0) || (dc > 0 && c + 1 >= w))
         return centre;
      return stored(r + dr, c + dc);
   endfunction

   function automatic logic [cup_pkg::SAMPLE_W-1:0] blend(int corner, int vert, int horz,
                                                          int centre);
      int acc;
      acc = corner + 3 * (vert + horz) + 9 * centre + 8;
      return cup_pkg::SAMPLE_W'(acc >> 4);
   endfunction

   function automatic upsampled_block_type block_at(int r, int c, int w, int h);
      upsampled_block_type blk;
      int ce, up, down, left, right;
      ce    = stored(r, c);
      up    = neighbor(r, c, -1, 0, w, h, ce);
      down  = neighbor(r, c, 1, 0, w, h, ce);
      left  = neighbor(r, c, 0, -1, w, h, ce);
      right = neighbor(r, c, 0, 1, w, h, ce);
      blk.block_col    = cup_pkg::BLOCK_POS_W'(c);
      blk.block_row    = cup_pkg::BLOCK_POS_W'(r);
      blk.top_left     = blend(neighbor(r, c, -1, -1, w, h, ce), up, left, ce);
      blk.top_right    = blend(neighbor(r, c, -1, 1, w, h, ce), up, right, ce);
      blk.bottom_left  = blend(neighbor(r, c, 1, -1, w, h, ce), down, left, ce);
      blk.bottom_right = blend(neighbor(r, c, 1, 1, w, h, ce), down, right, ce);
      blk.run_end      = 1'b0;
      return blk;
   endfunction

   function automatic void reset_upsampler_state();
      foreach (chroma_store[k])
         chroma_store[k] = '0;
      next_col       = 0;
      next_row       = 0;
      width_setting  = cup_pkg::DIM_W'(cup_pkg::RESET_CHROMA_WIDTH);
      height_setting = cup_pkg::DIM_W'(cup_pkg::RESET_CHROMA_HEIGHT);
   endfunction

   function automatic void apply_reg_write(logic [cup_pkg::CSR_INDEX_W-1:0] idx,
                                           logic [cup_pkg::DIM_W-1:0] value);
      if (idx == cup_pkg::REG_CHROMA_WIDTH) begin
         width_setting = value;
         next_col      = 0;
         next_row      = 0;
      end else if (idx == cup_pkg::REG_CHROMA_HEIGHT) begin
         height_setting = value;
         next_col       = 0;
         next_row       = 0;
      end
   endfunction

   // Store one sample and queue every block it completes, in raster order.
   function automatic void predict_blocks(logic [cup_pkg::SAMPLE_W-1:0] sample);
      int w, h, i, j, nr, nc;
      int rows[2];
      int cols[2];
      upsampled_block_type blk;
      w  = used_dim(width_setting, cup_pkg::MAX_CHROMA_WIDTH);
      h  = used_dim(height_setting, cup_pkg::MAX_CHROMA_HEIGHT);
      nr = 0;
      nc = 0;
      if (next_col >= w || next_row >= h) begin
         next_col = 0;
         next_row = 0;
      end
      i = next_row;
      j = next_col;
      chroma_store[(i % 3) * cup_pkg::MAX_CHROMA_WIDTH + j] = sample;
      if (i >= 1) begin
         rows[nr] = i - 1;
         nr++;
      end
      if (i + 1 == h) begin
         rows[nr] = i;
         nr++;
      end
      if (j >= 1) begin
         cols[nc] = j - 1;
         nc++;
      end
      if (j + 1 == w) begin
         cols[nc] = j;
         nc++;
      end
      for (int a = 0; a < nr; a++) begin
         for (int b = 0; b < nc; b++) begin
            blk         = block_at(rows[a], cols[b], w, h);
            blk.run_end = (a == nr - 1) && (b == nc - 1);
            expected_blocks.push_back(blk);
         end
      end
      next_col = j + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = i + 1;
         if (next_row >= h)
            next_row = 0;
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   // Sample driver: advance on acceptance, idle at random.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || sample_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_ch.sample <= pending_samples.pop_front();
            req_ch.valid  <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // Monitor: check results against the oldest expectation, predict on each sample.
   always @(posedge clock) begin
      upsampled_block_type want;
      sample_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_blocks.size() == 0) begin
               $error("unexpected result transaction: col %0d row %0d",
                      rsp_ch.block_col, rsp_ch.block_row);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_blocks.pop_front();
               check_field("block_col", want.block_col, rsp_ch.block_col);
               check_field("block_row", want.block_row, rsp_ch.block_row);
               check_field("top_left", want.top_left, rsp_ch.top_left);
               check_field("top_right", want.top_right, rsp_ch.top_right);
               check_field("bottom_left", want.bottom_left, rsp_ch.bottom_left);
               check_field("bottom_right", want.bottom_right, rsp_ch.bottom_right);
               check_field("run_end", want.run_end, rsp_ch.run_end);
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_blocks(req_ch.sample);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [cup_pkg::CSR_INDEX_W-1:0] idx,
                            logic [cup_pkg::DIM_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      apply_reg_write(idx, value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Hold the sender until every sample is taken and every block has arrived.
   task automatic settle();
      while (pending_samples.size() != 0 || req_ch.valid || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_samples(int unsigned count);
      for (int unsigned k = 0; k < count; k++)
         pending_samples.push_back(cup_pkg::SAMPLE_W'($urandom_range(255)));
   endtask

   initial begin
      int unsigned fed, count, frame;
      logic [cup_pkg::DIM_W-1:0] w_val, h_val;
      reset              = 1'b1;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = cup_pkg::REG_CHROMA_WIDTH;
      csr_ch.data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      rsp_ch.ready       = 1'b0;
      sample_taken       = 1'b0;
      quiet_cycles       = 0;
      mismatch_seen      = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset_upsampler_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x2 frame with extreme samples, then wrap into the next frame.
      write_reg(cup_pkg::REG_CHROMA_WIDTH, cup_pkg::DIM_W'(3));
      write_reg(cup_pkg::REG_CHROMA_HEIGHT, cup_pkg::DIM_W'(2));
      for (int k = 0; k < 9; k++)
         pending_samples.push_back((k % 2) ? '1 : '0);
      settle();

      // Zero dimensions act as a single-sample plane.
      write_reg(cup_pkg::REG_CHROMA_WIDTH, '0);
      write_reg(cup_pkg::REG_CHROMA_HEIGHT, '0);
      pending_samples.push_back('1);
      pending_samples.push_back('0);
      pending_samples.push_back(cup_pkg::SAMPLE_W'(8'h5A));
      settle();

      // Oversized dimensions clamp; first row alone completes nothing.
      write_reg(cup_pkg::REG_CHROMA_WIDTH, '1);
      write_reg(cup_pkg::REG_CHROMA_HEIGHT, '1);
      queue_random_samples(4);
      settle();
      write_reg(cup_pkg::REG_CHROMA_WIDTH, cup_pkg::DIM_W'(1));
      queue_random_samples(4);
      settle();

      // Unmapped writes mid-frame leave the frame position alone.
      write_reg(cup_pkg::REG_CHROMA_WIDTH, cup_pkg::DIM_W'(2));
      write_reg(cup_pkg::REG_CHROMA_HEIGHT, cup_pkg::DIM_W'(2));
      pending_samples.push_back('1);
      pending_samples.push_back('0);
      settle();
      write_reg(REG_UNMAPPED_3, '1);
      write_reg(REG_UNMAPPED_2, '0);
      pending_samples.push_back('0);
      pending_samples.push_back('1);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 47;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 47;
            end
            default: begin
               sender_idle_pct    = 25;
               receiver_stall_pct = 25;
            end
         endcase
         fed = 0;
         while (fed < PHASE_ITEMS) begin
            settle();
            case ($urandom_range(9))
               0: begin
                  // wide, flat plane: every sample after the first completes a block
                  w_val = cup_pkg::DIM_W'($urandom_range(100, 2047));
                  h_val = cup_pkg::DIM_W'($urandom_range(1));
                  count = $urandom_range(4, 12);
               end
               1: begin
                  // narrow, tall plane
                  w_val = cup_pkg::DIM_W'($urandom_range(3));
                  h_val = cup_pkg::DIM_W'($urandom_range(600, 2047));
                  count = $urandom_range(4, 10);
               end
               default: begin
                  w_val = cup_pkg::DIM_W'($urandom_range(1, 5));
                  h_val = cup_pkg::DIM_W'($urandom_range(1, 4));
                  frame = w_val * h_val;
                  count = $urandom_range(frame / 2 + 1, frame + w_val);
               end
            endcase
            if ($urandom_range(1)) begin
               write_reg(cup_pkg::REG_CHROMA_WIDTH, w_val);
               write_reg(cup_pkg::REG_CHROMA_HEIGHT, h_val);
            end else begin
               write_reg(cup_pkg::REG_CHROMA_HEIGHT, h_val);
               write_reg(cup_pkg::REG_CHROMA_WIDTH, w_val);
            end
            queue_random_samples(count);
            fed += count;
         end
      end

      settle();
      if (!mismatch_seen && expected_blocks.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
